// ===== hw/rtl/gpl_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register indexes and pipeline control types of the gradient pyramid level.
package gpl_pkg;

  localparam int PIX_W      = 16;
  localparam int PAIR_W     = 17;
  localparam int SUM_W      = 18;
  localparam int GRAD_W     = 17;
  localparam int PROD_W     = 32;
  localparam int SQ_W       = 33;
  localparam int CNT_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWNSAMPLE   = 2'd2;

  localparam logic [CNT_W-1:0] MIN_DIM      = 12'd3;
  localparam logic [CNT_W-1:0] FIRST_GRAD_ROW = 12'd2;
  localparam logic [CNT_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CNT_W-1:0] RESET_HEIGHT = 12'd480;

  typedef struct packed {
    logic emit;
    logic from_pair;
    logic grad_valid;
    logic frame_end;
  } step_t;

  typedef struct packed {
    logic valid;
    logic grad_valid;
    logic frame_end;
  } tag_t;

endpackage

// ===== hw/rtl/gpl_raster_ctrl.sv =====
`timescale 1ns / 1ps
// Raster position tracking, 2x2 phase control and line store addressing.
module gpl_raster_ctrl #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [gpl_pkg::PIX_W-1:0]       pixel,
  input  logic                            frame_start,
  input  logic [gpl_pkg::CNT_W-1:0]       level_width,
  input  logic [gpl_pkg::CNT_W-1:0]       level_height,
  input  logic                            downsample_enable,
  output gpl_pkg::step_t                  step,
  output logic [gpl_pkg::PAIR_W-1:0]      pair,
  output logic                            psum_write,
  output logic [$clog2(MAX_WIDTH)-1:0]    col_addr,
  output logic [$clog2(MAX_WIDTH)-1:0]    right_addr,
  output logic [$clog2(MAX_WIDTH)-1:0]    left_addr
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [gpl_pkg::CNT_W-1:0] column_count, column_count_next;
  logic [gpl_pkg::CNT_W-1:0] row_count, row_count_next;
  logic                      col_phase, col_phase_next;
  logic                      row_phase, row_phase_next;
  logic [gpl_pkg::PIX_W-1:0] held_left, held_left_next;

  logic [gpl_pkg::CNT_W-1:0] eff_w, eff_h, col, row;
  logic                      cph, rph, last_col, last_row;
  logic [AW-1:0]             x;

  always_comb begin
    eff_w = level_width;
    if (level_width < gpl_pkg::MIN_DIM) begin
      eff_w = gpl_pkg::MIN_DIM;
    end else if (32'(level_width) > MAX_WIDTH) begin
      eff_w = gpl_pkg::CNT_W'(MAX_WIDTH);
    end
    eff_h = (level_height < gpl_pkg::MIN_DIM) ? gpl_pkg::MIN_DIM : level_height;

    col = frame_start ? '0 : column_count;
    row = frame_start ? '0 : row_count;
    cph = frame_start ? 1'b0 : col_phase;
    rph = frame_start ? 1'b0 : row_phase;

    last_col = ((gpl_pkg::CNT_W+1)'(col) + 1'b1) >= (gpl_pkg::CNT_W+1)'(eff_w);
    last_row = ((gpl_pkg::CNT_W+1)'(row) + 1'b1) >= (gpl_pkg::CNT_W+1)'(eff_h);

    if (32'(col) >= MAX_WIDTH) begin
      x = AW'(MAX_WIDTH - 1);
    end else begin
      x = AW'(col);
    end
    col_addr   = x;
    right_addr = last_col ? '0 : x + 1'b1;
    left_addr  = (x == '0) ? AW'(eff_w - 1'b1) : x - 1'b1;
  end

  always_comb begin
    pair              = gpl_pkg::PAIR_W'(held_left) + gpl_pkg::PAIR_W'(pixel);
    step              = '0;
    psum_write        = 1'b0;
    column_count_next = col;
    row_count_next    = row;
    col_phase_next    = cph;
    row_phase_next    = rph;
    held_left_next    = held_left;

    if (!downsample_enable) begin
      col_phase_next = 1'b0;
      row_phase_next = 1'b0;
      step.emit      = 1'b1;
    end else if (!cph) begin
      held_left_next = pixel;
      col_phase_next = 1'b1;
    end else begin
      col_phase_next = 1'b0;
      if (!rph) begin
        psum_write = 1'b1;
        if (last_col) begin
          column_count_next = '0;
          row_phase_next    = 1'b1;
        end else begin
          column_count_next = col + 1'b1;
        end
      end else begin
        step.emit      = 1'b1;
        step.from_pair = 1'b1;
      end
    end

    if (step.emit) begin
      step.grad_valid = row >= gpl_pkg::FIRST_GRAD_ROW;
      step.frame_end  = last_col && last_row;
      if (last_col) begin
        column_count_next = '0;
        row_phase_next    = 1'b0;
        row_count_next    = last_row ? '0 : row + 1'b1;
      end else begin
        column_count_next = col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      col_phase    <= 1'b0;
      row_phase    <= 1'b0;
      held_left    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      col_phase    <= col_phase_next;
      row_phase    <= row_phase_next;
      held_left    <= held_left_next;
    end
  end

endmodule

// ===== hw/rtl/gpl_line_buf.sv =====
`timescale 1ns / 1ps
// Line memories, write forwarding and central differences of the level pixels.
module gpl_line_buf #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                s1_valid,
  input  gpl_pkg::step_t                      step,
  input  logic [gpl_pkg::PIX_W-1:0]           pixel,
  input  logic [gpl_pkg::PAIR_W-1:0]          pair,
  input  logic                                psum_write,
  input  logic [$clog2(MAX_WIDTH)-1:0]        col_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0]        right_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0]        left_addr,
  output gpl_pkg::tag_t                       tag,
  output logic [gpl_pkg::PIX_W-1:0]           level,
  output logic signed [gpl_pkg::GRAD_W-1:0]   gx,
  output logic signed [gpl_pkg::GRAD_W-1:0]   gy
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [gpl_pkg::PIX_W-1:0]  row_above [MAX_WIDTH];
  logic [gpl_pkg::PIX_W-1:0]  row_two   [MAX_WIDTH];
  logic [gpl_pkg::PAIR_W-1:0] pair_sums [MAX_WIDTH];

  logic [gpl_pkg::PIX_W-1:0]  ra_c_rd, ra_r_rd, rt_c_rd, rt_l_rd;
  logic [gpl_pkg::PAIR_W-1:0] ps_rd;

  logic                       valid2;
  logic [AW-1:0]              x2, r2, l2;
  logic                       from_pair2, gvalid2, fend2;
  logic [gpl_pkg::PIX_W-1:0]  pix2;
  logic [gpl_pkg::PAIR_W-1:0] pair2;

  logic                       valid3, gvalid3, fend3;
  logic [AW-1:0]              x3;
  logic [gpl_pkg::PIX_W-1:0]  level3, above3;
  logic signed [gpl_pkg::GRAD_W-1:0] gx3, gy3;

  logic [gpl_pkg::PIX_W-1:0]  level2, ra_c_fwd, right_fwd, center_fwd, left_fwd;
  logic                       hit_c, hit_r, hit_l;
  logic signed [gpl_pkg::GRAD_W-1:0] gx2, gy2;

  always_ff @(posedge clk) begin
    if (en) begin
      ra_c_rd <= row_above[col_addr];
      ra_r_rd <= row_above[right_addr];
      rt_c_rd <= row_two[col_addr];
      rt_l_rd <= row_two[left_addr];
      ps_rd   <= pair_sums[col_addr];
      if (s1_valid && psum_write) begin
        pair_sums[col_addr] <= pair;
      end
      if (valid2) begin
        row_above[x2] <= level2;
        row_two[x2]   <= ra_c_fwd;
      end
    end
  end

  // forward the word written by the word ahead in stage three; the memory read missed it
  always_comb begin
    level2     = from_pair2
               ? gpl_pkg::PIX_W'((gpl_pkg::SUM_W'(ps_rd) + gpl_pkg::SUM_W'(pair2)) >> 2)
               : pix2;
    hit_c      = valid3 && (x3 == x2);
    hit_r      = valid3 && (x3 == r2);
    hit_l      = valid3 && (x3 == l2);
    ra_c_fwd   = hit_c ? level3 : ra_c_rd;
    right_fwd  = hit_r ? level3 : ra_r_rd;
    center_fwd = hit_c ? above3 : rt_c_rd;
    left_fwd   = hit_l ? above3 : rt_l_rd;
    gx2 = '0;
    gy2 = '0;
    if (gvalid2) begin
      gx2 = $signed({1'b0, right_fwd}) - $signed({1'b0, left_fwd});
      gy2 = $signed({1'b0, level2}) - $signed({1'b0, center_fwd});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else if (en) begin
      valid2 <= s1_valid && step.emit;
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2         <= col_addr;
      r2         <= right_addr;
      l2         <= left_addr;
      from_pair2 <= step.from_pair;
      gvalid2    <= step.grad_valid;
      fend2      <= step.frame_end;
      pix2       <= pixel;
      pair2      <= pair;
      x3         <= x2;
      level3     <= level2;
      above3     <= ra_c_fwd;
      gx3        <= gx2;
      gy3        <= gy2;
      gvalid3    <= gvalid2;
      fend3      <= fend2;
    end
  end

  assign tag   = '{valid: valid3, grad_valid: gvalid3, frame_end: fend3};
  assign level = level3;
  assign gx    = gx3;
  assign gy    = gy3;

endmodule

// ===== hw/rtl/gpl_grad_mag.sv =====
`timescale 1ns / 1ps
// Gradient squares, magnitude sum and the result output register.
module gpl_grad_mag (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  gpl_pkg::tag_t                       tag_in,
  input  logic [gpl_pkg::PIX_W-1:0]           level_in,
  input  logic signed [gpl_pkg::GRAD_W-1:0]   gx_in,
  input  logic signed [gpl_pkg::GRAD_W-1:0]   gy_in,
  output logic                                result_valid,
  output logic [gpl_pkg::PIX_W-1:0]           level_pixel,
  output logic signed [gpl_pkg::GRAD_W-1:0]   grad_x,
  output logic signed [gpl_pkg::GRAD_W-1:0]   grad_y,
  output logic [gpl_pkg::SQ_W-1:0]            grad_sq,
  output logic                                grad_valid,
  output logic                                frame_end
);

  gpl_pkg::tag_t                      tag4;
  logic [gpl_pkg::PIX_W-1:0]          level4;
  logic signed [gpl_pkg::GRAD_W-1:0]  gx4, gy4;
  logic [gpl_pkg::PROD_W-1:0]         sqx4, sqy4;
  logic signed [2*gpl_pkg::GRAD_W-1:0] prod_x, prod_y;

  assign prod_x = gx_in * gx_in;
  assign prod_y = gy_in * gy_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag4         <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      tag4         <= tag_in;
      result_valid <= tag4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level4      <= level_in;
      gx4         <= gx_in;
      gy4         <= gy_in;
      sqx4        <= prod_x[gpl_pkg::PROD_W-1:0];
      sqy4        <= prod_y[gpl_pkg::PROD_W-1:0];
      level_pixel <= level4;
      grad_x      <= gx4;
      grad_y      <= gy4;
      grad_sq     <= gpl_pkg::SQ_W'(sqx4) + gpl_pkg::SQ_W'(sqy4);
      grad_valid  <= tag4.grad_valid;
      frame_end   <= tag4.frame_end;
    end
  end

  a_border_row_zero_squares: assert property (@(posedge clk) disable iff (rst)
    tag4.valid && !tag4.grad_valid |-> sqx4 == '0 && sqy4 == '0)
    else $error("squares nonzero on a border row");

endmodule

// ===== hw/rtl/gradient_pyramid_level_unit.sv =====
`timescale 1ns / 1ps
// Top level of one gradient pyramid level: config registers, input stage and pipeline.
//
// Takes one pixel word per clock while the output is not stalled and returns one result
// word per level pixel: every input pixel when downsampling is off, every fourth (the
// second pixel of the odd row of each 2x2 block) when it is on. A result passes the
// input register, line memory read, forwarding and differences, squares and sum
// before it leaves the output register. The rate of one pixel per cycle is set by the
// line memories, each written once at most and read at up to two addresses per cycle.
// The line memories are not cleared; write width, height and mode while idle.
module gradient_pyramid_level_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gpl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gpl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [gpl_pkg::PIX_W-1:0]           pixel_in,
  input  logic                                frame_start,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  output logic [gpl_pkg::PIX_W-1:0]           level_pixel,
  output logic signed [gpl_pkg::GRAD_W-1:0]   grad_x,
  output logic signed [gpl_pkg::GRAD_W-1:0]   grad_y,
  output logic [gpl_pkg::SQ_W-1:0]            grad_sq,
  output logic                                grad_valid,
  output logic                                frame_end,
  output logic                                result_valid,
  input  logic                                result_stall
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [gpl_pkg::CNT_W-1:0] level_width, level_height;
  logic                      downsample_enable;

  logic                      en, advance;
  logic                      s1_valid, s1_frame_start;
  logic [gpl_pkg::PIX_W-1:0] s1_pixel;

  gpl_pkg::step_t             step;
  logic [gpl_pkg::PAIR_W-1:0] pair;
  logic                       psum_write;
  logic [AW-1:0]              col_addr, right_addr, left_addr;

  gpl_pkg::tag_t                     tag3;
  logic [gpl_pkg::PIX_W-1:0]         level3;
  logic signed [gpl_pkg::GRAD_W-1:0] gx3, gy3;

  // advance the whole pipeline unless the output word is held
  assign en          = !(result_valid && result_stall);
  assign pixel_stall = !en;
  assign advance     = en && s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_width       <= gpl_pkg::RESET_WIDTH;
      level_height      <= gpl_pkg::RESET_HEIGHT;
      downsample_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        gpl_pkg::REG_LEVEL_WIDTH:  level_width       <= cfg_data;
        gpl_pkg::REG_LEVEL_HEIGHT: level_height      <= cfg_data;
        gpl_pkg::REG_DOWNSAMPLE:   downsample_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pixel       <= pixel_in;
      s1_frame_start <= frame_start;
    end
  end

  gpl_raster_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_raster_ctrl (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .pixel            (s1_pixel),
    .frame_start      (s1_frame_start),
    .level_width      (level_width),
    .level_height     (level_height),
    .downsample_enable(downsample_enable),
    .step             (step),
    .pair             (pair),
    .psum_write       (psum_write),
    .col_addr         (col_addr),
    .right_addr       (right_addr),
    .left_addr        (left_addr)
  );

  gpl_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s1_valid  (s1_valid),
    .step      (step),
    .pixel     (s1_pixel),
    .pair      (pair),
    .psum_write(psum_write),
    .col_addr  (col_addr),
    .right_addr(right_addr),
    .left_addr (left_addr),
    .tag       (tag3),
    .level     (level3),
    .gx        (gx3),
    .gy        (gy3)
  );

  gpl_grad_mag u_grad_mag (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .tag_in      (tag3),
    .level_in    (level3),
    .gx_in       (gx3),
    .gy_in       (gy3),
    .result_valid(result_valid),
    .level_pixel (level_pixel),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .grad_sq     (grad_sq),
    .grad_valid  (grad_valid),
    .frame_end   (frame_end)
  );

  a_border_row_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !grad_valid |-> grad_sq == '0 && grad_x == '0 && grad_y == '0)
    else $error("gradient fields nonzero on a border row");

  a_frame_end_interior: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> grad_valid)
    else $error("frame end on a row without gradient");

endmodule

// ===== bench/gradient_pyramid_level_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for one gradient pyramid level with an in-order prediction of every result word.
module gradient_pyramid_level_unit_tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int SETTLE       = 8;
  localparam int LINE_DEPTH   = 2048;

  typedef struct packed {
    logic [gpl_pkg::PIX_W-1:0]         level_pixel;
    logic signed [gpl_pkg::GRAD_W-1:0] grad_x;
    logic signed [gpl_pkg::GRAD_W-1:0] grad_y;
    logic [gpl_pkg::SQ_W-1:0]          grad_sq;
    logic                              grad_valid;
    logic                              frame_end;
  } level_result_t;

  logic                              clk;
  logic                              rst;
  logic                              cfg_write;
  logic [gpl_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [gpl_pkg::CFG_DATA_W-1:0]    cfg_data;
  logic [gpl_pkg::PIX_W-1:0]         pixel_in;
  logic                              frame_start;
  logic                              pixel_valid;
  logic                              pixel_stall;
  logic [gpl_pkg::PIX_W-1:0]         level_pixel;
  logic signed [gpl_pkg::GRAD_W-1:0] grad_x;
  logic signed [gpl_pkg::GRAD_W-1:0] grad_y;
  logic [gpl_pkg::SQ_W-1:0]          grad_sq;
  logic                              grad_valid;
  logic                              frame_end;
  logic                              result_valid;
  logic                              result_stall;

  logic [gpl_pkg::CNT_W-1:0]  reg_width;
  logic [gpl_pkg::CNT_W-1:0]  reg_height;
  logic                       reg_downsample;
  logic [gpl_pkg::CNT_W-1:0]  col_pos;
  logic [gpl_pkg::CNT_W-1:0]  row_pos;
  logic                       col_odd;
  logic                       row_odd;
  logic [gpl_pkg::PIX_W-1:0]  held_left;
  logic [gpl_pkg::PIX_W-1:0]  above_row [0:LINE_DEPTH-1];
  logic [gpl_pkg::PIX_W-1:0]  two_above_row [0:LINE_DEPTH-1];
  logic [gpl_pkg::PAIR_W-1:0] pair_sums [0:LINE_DEPTH-1];

  level_result_t pending_results[$];
  level_result_t expected_word;

  bit quiet_flow;
  int pixels_sent;
  int results_checked;
  int frames_closed;
  int config_writes;
  int mismatch_count;
  int cycle_count;

  gradient_pyramid_level_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_in     (pixel_in),
    .frame_start  (frame_start),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .level_pixel  (level_pixel),
    .grad_x       (grad_x),
    .grad_y       (grad_y),
    .grad_sq      (grad_sq),
    .grad_valid   (grad_valid),
    .frame_end    (frame_end),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int eff_width_of(logic [gpl_pkg::CNT_W-1:0] w);
    if (w < gpl_pkg::MIN_DIM) return 3;
    if (int'(w) > LINE_DEPTH) return LINE_DEPTH;
    return int'(w);
  endfunction

  function automatic int eff_height_of(logic [gpl_pkg::CNT_W-1:0] h);
    return (h < gpl_pkg::MIN_DIM) ? 3 : int'(h);
  endfunction

  function automatic logic [gpl_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return gpl_pkg::PIX_W'($urandom);
    endcase
  endfunction

  task automatic emit_level(input logic [gpl_pkg::PIX_W-1:0] v);
    int w;
    int x;
    int gx;
    int gy;
    logic last_col;
    logic last_row;
    logic in_rows;
    logic [gpl_pkg::PIX_W-1:0] right;
    logic [gpl_pkg::PIX_W-1:0] left;
    longint sq;
    level_result_t r;
    w = eff_width_of(reg_width);
    x = (int'(col_pos) >= LINE_DEPTH) ? LINE_DEPTH - 1 : int'(col_pos);
    last_col = (int'(col_pos) + 1 >= w);
    last_row = (int'(row_pos) + 1 >= eff_height_of(reg_height));
    in_rows = (row_pos >= gpl_pkg::FIRST_GRAD_ROW);
    right = last_col ? above_row[0] : above_row[x + 1];
    left = (x == 0) ? two_above_row[w - 1] : two_above_row[x - 1];
    gx = int'(right) - int'(left);
    gy = int'(v) - int'(two_above_row[x]);
    sq = longint'(gx) * gx + longint'(gy) * gy;
    two_above_row[x] = above_row[x];
    above_row[x] = v;
    r.level_pixel = v;
    r.grad_x = in_rows ? gx[gpl_pkg::GRAD_W-1:0] : '0;
    r.grad_y = in_rows ? gy[gpl_pkg::GRAD_W-1:0] : '0;
    r.grad_sq = in_rows ? sq[gpl_pkg::SQ_W-1:0] : '0;
    r.grad_valid = in_rows;
    r.frame_end = last_col && last_row;
    pending_results = {pending_results, r};
    if (last_col) begin
      col_pos = '0;
      row_odd = 1'b0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic predict_level(input logic [gpl_pkg::PIX_W-1:0] pix, input logic fs);
    logic [gpl_pkg::PAIR_W-1:0] pair;
    logic [gpl_pkg::SUM_W-1:0] block_sum;
    int x;
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
      col_odd = 1'b0;
      row_odd = 1'b0;
    end
    if (!reg_downsample) begin
      col_odd = 1'b0;
      row_odd = 1'b0;
      emit_level(pix);
    end else if (!col_odd) begin
      held_left = pix;
      col_odd = 1'b1;
    end else begin
      col_odd = 1'b0;
      pair = held_left + pix;
      x = (int'(col_pos) >= LINE_DEPTH) ? LINE_DEPTH - 1 : int'(col_pos);
      if (!row_odd) begin
        pair_sums[x] = pair;
        if (int'(col_pos) + 1 >= eff_width_of(reg_width)) begin
          col_pos = '0;
          row_odd = 1'b1;
        end else begin
          col_pos = col_pos + 1'b1;
        end
      end else begin
        block_sum = pair_sums[x] + pair;
        emit_level(block_sum[gpl_pkg::SUM_W-1:2]);
      end
    end
  endtask

  task automatic write_register(input logic [gpl_pkg::CFG_IDX_W-1:0] idx,
                                input logic [gpl_pkg::CFG_DATA_W-1:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    case (idx)
      gpl_pkg::REG_LEVEL_WIDTH:  reg_width = value;
      gpl_pkg::REG_LEVEL_HEIGHT: reg_height = value;
      gpl_pkg::REG_DOWNSAMPLE:   reg_downsample = value[0];
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_level(input int w, input int h, input bit ds);
    write_register(gpl_pkg::REG_LEVEL_WIDTH, gpl_pkg::CFG_DATA_W'(w));
    write_register(gpl_pkg::REG_LEVEL_HEIGHT, gpl_pkg::CFG_DATA_W'(h));
    write_register(gpl_pkg::REG_DOWNSAMPLE, gpl_pkg::CFG_DATA_W'(ds));
  endtask

  task automatic send_pixel(input logic [gpl_pkg::PIX_W-1:0] pix, input logic fs);
    int gap;
    gap = quiet_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      pixel_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_in = pix;
    frame_start = fs;
    pixel_valid = 1'b1;
    do @(posedge clk); while (pixel_stall);
    predict_level(pix, fs);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    pixel_valid = 1'b0;
    frame_start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    int i;
    quiet_flow = 1'b0;
    for (i = 0; i < 20; i++) send_pixel(pick_pixel(), 1'b0);
    drain_results();
  endtask

  task automatic test_passthrough_extremes();
    int i;
    quiet_flow = 1'b0;
    set_level(3, 3, 1'b0);
    for (i = 0; i < 9; i++) send_pixel((i % 4 < 2) ? 16'h0000 : 16'hFFFF, i == 0);
    // wrap into the next frame without a frame start, inverted levels
    for (i = 0; i < 9; i++) send_pixel((i % 4 < 2) ? 16'hFFFF : 16'h0000, 1'b0);
    for (i = 0; i < 5; i++) send_pixel(pick_pixel(), i == 3);
    drain_results();
  endtask

  task automatic test_downsample_average();
    int i;
    quiet_flow = 1'b0;
    set_level(1, 2, 1'b1);
    for (i = 0; i < 36; i++) begin
      send_pixel((i % 3 == 0) ? 16'hFFFF : (i % 5 == 0) ? 16'h0000 :
                 gpl_pkg::PIX_W'(i * 16'h0101 + 1), i == 0);
    end
    for (i = 0; i < 14; i++) send_pixel(pick_pixel(), 1'b0);
    drain_results();
  endtask

  task automatic test_shrink_mid_frame();
    int i;
    quiet_flow = 1'b0;
    set_level(8, 4095, 1'b0);
    for (i = 0; i < 30; i++) send_pixel(pick_pixel(), i == 0);
    drain_results();
    // position now lies past the new last column and last row
    write_register(gpl_pkg::REG_LEVEL_WIDTH, 12'd0);
    write_register(gpl_pkg::REG_LEVEL_HEIGHT, 12'd3);
    for (i = 0; i < 13; i++) send_pixel(pick_pixel(), 1'b0);
    drain_results();
  endtask

  task automatic test_mode_switch();
    int i;
    quiet_flow = 1'b0;
    set_level(4, 3, 1'b1);
    for (i = 0; i < 13; i++) send_pixel(pick_pixel(), i == 0);
    drain_results();
    write_register(gpl_pkg::REG_DOWNSAMPLE, 12'd0);
    for (i = 0; i < 10; i++) send_pixel(pick_pixel(), 1'b0);
    drain_results();
    write_register(gpl_pkg::REG_DOWNSAMPLE, 12'd1);
    for (i = 0; i < 48; i++) send_pixel(pick_pixel(), i == 0);
    drain_results();
  endtask

  task automatic test_clamped_extremes();
    int i;
    quiet_flow = 1'b1;
    set_level(4095, 0, 1'b0);
    for (i = 0; i < 64; i++) send_pixel(pick_pixel(), i == 0);
    drain_results();
    quiet_flow = 1'b0;
  endtask

  task automatic test_random_streams();
    int sent;
    int w;
    int h;
    int total;
    int i;
    bit ds;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      ds = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 2);
        1: w = ds ? $urandom_range(13, 20) : $urandom_range(13, 40);
        default: w = $urandom_range(3, 12);
      endcase
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      drain_results();
      set_level(w, h, ds);
      quiet_flow = ($urandom_range(0, 3) == 0);
      total = $urandom_range(1, 3) * eff_width_of(gpl_pkg::CNT_W'(w))
              * eff_height_of(gpl_pkg::CNT_W'(h)) * (ds ? 4 : 1);
      if ($urandom_range(0, 3) == 0) total = $urandom_range(1, total);
      for (i = 0; i < total; i++) begin
        send_pixel(pick_pixel(), (i == 0) || ($urandom_range(0, 199) == 0));
        if (i % 64 == 63) quiet_flow = ($urandom_range(0, 3) == 0);
      end
      sent += total;
    end
    drain_results();
    quiet_flow = 1'b0;
  endtask

  initial begin : result_sink
    int hold;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = quiet_flow ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        result_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall = 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      if (frame_end) frames_closed++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected word: pix=%h gx=%0d gy=%0d sq=%0d gv=%b fe=%b",
                   level_pixel, grad_x, grad_y, grad_sq, grad_valid, frame_end);
        end
      end else begin
        expected_word = pending_results.pop_front();
        if (level_pixel !== expected_word.level_pixel || grad_x !== expected_word.grad_x ||
            grad_y !== expected_word.grad_y || grad_sq !== expected_word.grad_sq ||
            grad_valid !== expected_word.grad_valid ||
            frame_end !== expected_word.frame_end) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("word %0d expected: pix=%h gx=%0d gy=%0d sq=%0d gv=%b fe=%b",
                     results_checked, expected_word.level_pixel, expected_word.grad_x,
                     expected_word.grad_y, expected_word.grad_sq, expected_word.grad_valid,
                     expected_word.frame_end);
            $display("word %0d actual:   pix=%h gx=%0d gy=%0d sq=%0d gv=%b fe=%b",
                     results_checked, level_pixel, grad_x, grad_y, grad_sq, grad_valid,
                     frame_end);
          end
        end
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int i;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixel_in = '0;
    frame_start = 1'b0;
    pixel_valid = 1'b0;
    quiet_flow = 1'b0;
    reg_width = gpl_pkg::RESET_WIDTH;
    reg_height = gpl_pkg::RESET_HEIGHT;
    reg_downsample = 1'b0;
    col_pos = '0;
    row_pos = '0;
    col_odd = 1'b0;
    row_odd = 1'b0;
    held_left = '0;
    for (i = 0; i < LINE_DEPTH; i++) begin
      above_row[i] = '0;
      two_above_row[i] = '0;
      pair_sums[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_passthrough_extremes();
    test_downsample_average();
    test_shrink_mid_frame();
    test_mode_switch();
    test_clamped_extremes();
    test_random_streams();

    pixel_valid = 1'b0;
    for (i = 0; i < 5000 && pending_results.size() != 0; i++) @(negedge clk);
    repeat (12) @(negedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0d expected words never arrived", pending_results.size());
    end
    $display("Sent %0d pixels over %0d register writes; checked %0d level words, %0d frame ends",
             pixels_sent, config_writes, results_checked, frames_closed);
    $display("Covered pass-through and 2x2 averaging, clamped sizes, mid-frame shrink, mode switch");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
